>>> sv/periodic_task_tick_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task tick scheduler
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// Check that an expression holds at every edge out of reset
`define PTTS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle
`define PTTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle
`define PTTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Beat types, table entry type and command and status codes of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

    // Most firings reported for one tick
    localparam int MAX_RESULTS = 16;
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_TICK   = 2'd0;
    localparam cmd_code_t CMD_ADD    = 2'd1;
    localparam cmd_code_t CMD_REMOVE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_NONE_DUE  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  task_id;
        logic [31:0] period;
        logic [7:0]  priority_req;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0] fired_id;
        logic [1:0] status;
        logic       last;
    } res_beat_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] period;
        logic [31:0] countdown;
        logic [7:0]  prio;
    } entry_t;

    typedef struct packed {
        logic fire;
        logic prio_gt;
        logic id_match;
    } eval_flags_t;

endpackage

`default_nettype wire

>>> sv/ptts_step_unit.sv
// ----------------------------------------------------------------------------
// ptts_step_unit
// Shared compare and decrement unit applied to one table entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_step_unit (
    input  ptts_pkg::entry_t      entry,
    input  logic [7:0]            key_id,
    input  logic [7:0]            key_prio,
    output ptts_pkg::eval_flags_t flags,
    output logic [31:0]           countdown_next
);
    import ptts_pkg::*;

    logic [31:0] dec_operand;

    // Compare against the operation key
    assign flags.fire     = (entry.countdown == 32'd0);
    assign flags.prio_gt  = (entry.prio > key_prio);
    assign flags.id_match = (entry.id == key_id);

    // Reload from period minus one when due, else count down; saturate at zero
    assign dec_operand    = flags.fire ? entry.period : entry.countdown;
    assign countdown_next = (dec_operand == 32'd0) ? 32'd0 : dec_operand - 32'd1;

endmodule

`default_nettype wire

>>> sv/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Priority-sorted periodic task table walked one entry per cycle; ticks may stall.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_data) takes one command beat:
//   tick, add task or remove task. cmd_stall is high while a command is being
//   worked on; the block takes one command at a time.
//   res channel (res_valid / res_stall / res_data) gives the result beats of
//   a command; the final beat of each command carries last = 1. A tick gives
//   one beat per reported firing in table order, or one none-due beat.
//   A command that is not rejected walks the table through one memory read
//   port, one entry per cycle, except while a tick halts for the receiver.
//   A finished beat sits in the output register while the next command is
//   taken. When the receiver stalls, the walk halts on the next firing that
//   must be reported and resumes once the output register frees up.
//   Reset clears the entry count and all control state; table contents are
//   not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_tick_scheduler_macros.svh"

module periodic_task_tick_scheduler #(
    parameter int TASKS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ptts_pkg::cmd_beat_t cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output ptts_pkg::res_beat_t res_data
);
    import ptts_pkg::*;

    localparam int AW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_TICK      = 3'd1;
    localparam logic [2:0] S_ADD       = 3'd2;
    localparam logic [2:0] S_PUT       = 3'd3;
    localparam logic [2:0] S_REM_SCAN  = 3'd4;
    localparam logic [2:0] S_REM_SHIFT = 3'd5;
    localparam logic [2:0] S_FINAL     = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [NW-1:0] n_reg, n_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_id_reg, pend_id_next;
    status_t       fin_status_reg, fin_status_next;
    logic [7:0]    key_id_reg, key_id_next;
    logic [31:0]   key_period_reg, key_period_next;
    logic [7:0]    key_prio_reg, key_prio_next;
    logic          res_valid_reg;
    res_beat_t     res_data_reg;

    // Table memory with one write and one registered read port
    entry_t        table_mem [TASKS];
    entry_t        rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    entry_t        mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    eval_flags_t   flags;
    logic [31:0]   countdown_next;
    logic          can_emit;
    logic          emit;
    res_beat_t     emit_beat;
    entry_t        new_entry;
    logic [CW-1:0] idx_ext, idx_p1, idx_p2;

    ptts_step_unit u_step (
        .entry          (rd_data_reg),
        .key_id         (key_id_reg),
        .key_prio       (key_prio_reg),
        .flags          (flags),
        .countdown_next (countdown_next)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign can_emit  = !res_valid_reg || !res_stall;

    assign idx_ext = CW'(idx_reg);
    assign idx_p1  = idx_ext + CW'(1);
    assign idx_p2  = idx_ext + CW'(2);

    assign new_entry.id        = key_id_reg;
    assign new_entry.period    = key_period_reg;
    assign new_entry.countdown = key_period_reg;
    assign new_entry.prio      = key_prio_reg;

    // Sequence the table walk
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        fin_status_next = fin_status_reg;
        key_id_next     = key_id_reg;
        key_period_next = key_period_reg;
        key_prio_next   = key_prio_reg;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = rd_data_reg;
        mem_re          = 1'b0;
        mem_ra          = idx_reg;
        emit            = 1'b0;
        emit_beat       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_id_next     = cmd_data.task_id;
                    key_period_next = cmd_data.period;
                    key_prio_next   = cmd_data.priority_req;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    case (cmd_data.command)
                        CMD_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                fin_status_next = ST_NONE_DUE;
                                state_next      = S_FINAL;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = '0;
                                idx_next   = '0;
                                state_next = S_TICK;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (count_reg == CW'(TASKS))
                            begin
                                fin_status_next = ST_FULL;
                                state_next      = S_FINAL;
                            end
                            else if (count_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg);
                                state_next = S_ADD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin_status_next = ST_NOT_FOUND;
                                state_next      = S_FINAL;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = '0;
                                idx_next   = '0;
                                state_next = S_REM_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                // Hold when a firing must push out a pending beat that cannot leave
                if (!(flags.fire && n_reg < NW'(MAX_RESULTS) && pend_valid_reg && !can_emit))
                begin
                    mem_we           = 1'b1;
                    mem_wd.countdown = countdown_next;
                    if (flags.fire && n_reg < NW'(MAX_RESULTS))
                    begin
                        if (pend_valid_reg)
                        begin
                            emit               = 1'b1;
                            emit_beat.fired_id = pend_id_reg;
                            emit_beat.status   = ST_OK;
                            emit_beat.last     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_data_reg.id;
                        n_next          = n_reg + NW'(1);
                    end
                    if (idx_p1 == count_reg)
                    begin
                        fin_status_next = ST_NONE_DUE;
                        state_next      = S_FINAL;
                    end
                    else
                    begin
                        mem_re   = 1'b1;
                        mem_ra   = AW'(idx_p1);
                        idx_next = AW'(idx_p1);
                    end
                end
            end

            S_ADD:
            begin
                // Shift larger priorities up one slot, then drop the new task in
                mem_we = 1'b1;
                if (flags.prio_gt)
                begin
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_ra = idx_reg - AW'(2);
                    end
                end
                else
                begin
                    mem_wd          = new_entry;
                    count_next      = count_reg + CW'(1);
                    fin_status_next = ST_OK;
                    state_next      = S_FINAL;
                end
            end

            S_PUT:
            begin
                mem_we          = 1'b1;
                mem_wd          = new_entry;
                count_next      = count_reg + CW'(1);
                fin_status_next = ST_OK;
                state_next      = S_FINAL;
            end

            S_REM_SCAN:
            begin
                if (flags.id_match)
                begin
                    if (idx_p1 == count_reg)
                    begin
                        count_next      = count_reg - CW'(1);
                        fin_status_next = ST_OK;
                        state_next      = S_FINAL;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_ra     = AW'(idx_p1);
                        state_next = S_REM_SHIFT;
                    end
                end
                else if (idx_p1 == count_reg)
                begin
                    fin_status_next = ST_NOT_FOUND;
                    state_next      = S_FINAL;
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = AW'(idx_p1);
                    idx_next = AW'(idx_p1);
                end
            end

            S_REM_SHIFT:
            begin
                // Close the gap one entry at a time
                mem_we   = 1'b1;
                idx_next = AW'(idx_p1);
                if (idx_p2 == count_reg)
                begin
                    count_next      = count_reg - CW'(1);
                    fin_status_next = ST_OK;
                    state_next      = S_FINAL;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = AW'(idx_p2);
                end
            end

            S_FINAL:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_beat.fired_id = pend_id_reg;
                        emit_beat.status   = ST_OK;
                    end
                    else
                    begin
                        emit_beat.fired_id = 8'd0;
                        emit_beat.status   = fin_status_reg;
                    end
                    emit_beat.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        fin_status_reg <= fin_status_next;
        key_id_reg     <= key_id_next;
        key_period_reg <= key_period_next;
        key_prio_reg   <= key_prio_next;
        if (emit)
        begin
            res_data_reg <= emit_beat;
        end
    end

    // Table memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_ra];
        end
    end

    // Checks on the sequencer
    `PTTS_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TASKS), "entry count exceeds table size")
    `PTTS_ASSERT_IMPLY(a_write_busy, mem_we, state_reg != S_IDLE && state_reg != S_FINAL, "table written outside a walk")
    `PTTS_ASSERT_NEXT(a_full_add, cmd_valid && !cmd_stall && cmd_data.command == CMD_ADD && count_reg == CW'(TASKS), state_reg == S_FINAL && fin_status_reg == ST_FULL && count_reg == CW'(TASKS), "add on full table not rejected")
    `PTTS_ASSERT_NEXT(a_idle_count, state_reg == S_IDLE, count_reg == $past(count_reg), "entry count moved while idle")

endmodule

`default_nettype wire

>>> test/periodic_task_tick_scheduler_test.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_test
// Drives tick, add and remove commands into the scheduler with random gaps
// on both channels. A scoreboard keeps its own copy of the task table,
// predicts every result beat and compares each beat as it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_test;

    import ptts_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int RANDOM_ITEMS   = 425;
    localparam int HOLD_AT_ITEM   = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int LIMIT_CYCLES   = 600_000;
    localparam cmd_code_t CMD_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: task table copy and queue of expected result beats
    // ------------------------------------------------------------------------
    class sched_scoreboard;
        entry_t    slots[$];
        res_beat_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function void push_result(logic [7:0] id, status_t st, logic fin);
            res_beat_t r;
            r.fired_id = id;
            r.status   = st;
            r.last     = fin;
            pending.push_back(r);
        endfunction

        // Walk the table: fire due entries, count down the rest
        function void run_tick();
            entry_t    e;
            res_beat_t r;
            int        fired;
            fired = 0;
            for (int i = 0; i < slots.size(); i++)
            begin
                e = slots[i];
                if (e.countdown == 32'd0)
                begin
                    e.countdown = (e.period == 32'd0) ? 32'd0 : e.period - 32'd1;
                    if (fired < MAX_RESULTS)
                    begin
                        push_result(e.id, ST_OK, 1'b0);
                        fired++;
                    end
                end
                else
                begin
                    e.countdown = e.countdown - 32'd1;
                end
                slots[i] = e;
            end
            if (fired == 0)
            begin
                push_result(8'd0, ST_NONE_DUE, 1'b1);
            end
            else
            begin
                r      = pending.pop_back();
                r.last = 1'b1;
                pending.push_back(r);
            end
        endfunction

        // Insert behind every entry of equal or lower priority value
        function void run_add(cmd_beat_t b);
            entry_t e;
            int     pos;
            if (slots.size() >= TABLE_DEPTH)
            begin
                push_result(8'd0, ST_FULL, 1'b1);
                return;
            end
            pos = 0;
            while (pos < slots.size() && slots[pos].prio <= b.priority_req)
                pos++;
            e.id        = b.task_id;
            e.period    = b.period;
            e.countdown = b.period;
            e.prio      = b.priority_req;
            slots.insert(pos, e);
            push_result(8'd0, ST_OK, 1'b1);
        endfunction

        // Drop the first entry with a matching id
        function void run_remove(cmd_beat_t b);
            for (int i = 0; i < slots.size(); i++)
            begin
                if (slots[i].id == b.task_id)
                begin
                    slots.delete(i);
                    push_result(8'd0, ST_OK, 1'b1);
                    return;
                end
            end
            push_result(8'd0, ST_NOT_FOUND, 1'b1);
        endfunction

        function void note_command(cmd_beat_t b);
            case (b.command)
                CMD_TICK:   run_tick();
                CMD_ADD:    run_add(b);
                CMD_REMOVE: run_remove(b);
                default:    ;
            endcase
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, want, got);
        endfunction

        function void check_result(res_beat_t got);
            res_beat_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, actual %0h/%0h/%0b",
                         $time, got.fired_id, got.status, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.fired_id !== want.fired_id)
                report("fired_id", want.fired_id, got.fired_id);
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs and instance
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    cmd_beat_t cmd_data  = '0;
    logic      res_stall = 1'b0;
    logic      cmd_stall;
    logic      res_valid;
    res_beat_t res_data;

    sched_scoreboard sb = new();
    int              tx_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    periodic_task_tick_scheduler #(
        .TASKS (TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    function automatic cmd_beat_t make_cmd(cmd_code_t c, logic [7:0] id,
                                           logic [31:0] per, logic [7:0] prio);
        cmd_beat_t b;
        b.command      = c;
        b.task_id      = id;
        b.period       = per;
        b.priority_req = prio;
        return b;
    endfunction

    // Mostly ids and priorities from a small pool so removes hit and ties occur
    function automatic cmd_beat_t random_command();
        cmd_beat_t b;
        int        r;
        int        p;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 19);
        if (r < 45)
            b.command = CMD_TICK;
        else if (r < 75)
            b.command = CMD_ADD;
        else if (r < 96)
            b.command = CMD_REMOVE;
        else
            b.command = CMD_UNUSED;
        b.task_id = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                : 8'(8'h20 + $urandom_range(0, 15));
        b.priority_req = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 3));
        if (p == 0)
            b.period = 32'd0;
        else if (p < 3)
            b.period = $urandom;
        else
            b.period = 32'($urandom_range(1, 6));
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send(input cmd_beat_t b);
        int gap;
        gap = (tx_count % 40 < 10) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_data  <= b;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(b);
        tx_count++;
    endtask

    initial
    begin : stimulus
        cmd_beat_t b;
        int        counted;
        counted = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty table, extreme fields, period zero, unused code
        send(make_cmd(CMD_TICK,   8'h00, 32'h0000_0000, 8'h00));
        send(make_cmd(CMD_REMOVE, 8'h05, 32'h0000_0001, 8'h00));
        send(make_cmd(CMD_ADD,    8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send(make_cmd(CMD_ADD,    8'h00, 32'h0000_0000, 8'h00));
        send(make_cmd(CMD_ADD,    8'hAA, 32'h0000_0001, 8'h55));
        send(make_cmd(CMD_TICK,   8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send(make_cmd(CMD_TICK,   8'h00, 32'h0000_0000, 8'h00));
        send(make_cmd(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send(make_cmd(CMD_REMOVE, 8'hAA, 32'h0000_0000, 8'h00));
        send(make_cmd(CMD_REMOVE, 8'hAA, 32'h0000_0000, 8'h00));

        // Fill the table, overflow it, then tick twice; the second tick fires all but id FF
        for (int k = 0; k < TABLE_DEPTH - 2; k++)
            send(make_cmd(CMD_ADD, 8'(8'h20 + k), 32'd1, 8'(k % 3)));
        send(make_cmd(CMD_ADD,  8'h77, 32'd3, 8'h01));
        send(make_cmd(CMD_TICK, 8'h00, 32'd0, 8'h00));
        send(make_cmd(CMD_TICK, 8'h00, 32'd0, 8'h00));

        // Random mix; unused codes do not count
        while (counted < RANDOM_ITEMS)
        begin
            b = random_command();
            send(b);
            if (b.command != CMD_UNUSED)
                counted++;
        end
        cmd_valid <= 1'b0;

        // Drain, then give the block time to show any stray beat
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.errors++;

        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check taken beats, stall at random, one long hold
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int rx_gap;
        int rx_count;
        int hold_left;
        bit held;
        rx_gap    = 0;
        rx_count  = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                sb.check_result(res_data);
                rx_count++;
                rx_gap = (rx_count % 40 < 10) ? 0 : $urandom_range(0, 12);
            end
            if (!held && tx_count >= HOLD_AT_ITEM)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            // Hold for the long stretch first, then the per-beat gap
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        #(LIMIT_CYCLES * 12);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
